// File: rtl/core/gcp_pkg.sv
// Shared types, codes and helpers of the GIF container stream parser.
`default_nettype none

package gcp_pkg;

  typedef enum logic [2:0] {
    EV_SCREEN  = 3'd0,
    EV_PAL     = 3'd1,
    EV_IMAGE   = 3'd2,
    EV_DATA    = 3'd3,
    EV_END     = 3'd4,
    EV_TRAILER = 3'd5,
    EV_ERROR   = 3'd6
  } event_e;

  localparam int unsigned PhaseW = 4;

  localparam logic [PhaseW-1:0] PH_SIG      = 4'd0;
  localparam logic [PhaseW-1:0] PH_LSD      = 4'd1;
  localparam logic [PhaseW-1:0] PH_GPAL     = 4'd2;
  localparam logic [PhaseW-1:0] PH_INTRO    = 4'd3;
  localparam logic [PhaseW-1:0] PH_IDESC    = 4'd4;
  localparam logic [PhaseW-1:0] PH_LPAL     = 4'd5;
  localparam logic [PhaseW-1:0] PH_CODESIZE = 4'd6;
  localparam logic [PhaseW-1:0] PH_BLKLEN   = 4'd7;
  localparam logic [PhaseW-1:0] PH_BLKDATA  = 4'd8;
  localparam logic [PhaseW-1:0] PH_EXTLABEL = 4'd9;
  localparam logic [PhaseW-1:0] PH_DONE     = 4'd10;
  localparam logic [PhaseW-1:0] PH_HALT     = 4'd11;

  localparam logic [7:0] INTRO_IMAGE   = 8'h2C;
  localparam logic [7:0] INTRO_EXT     = 8'h21;
  localparam logic [7:0] INTRO_TRAILER = 8'h3B;

  localparam logic [7:0] SIG_G      = 8'h47;
  localparam logic [7:0] SIG_I      = 8'h49;
  localparam logic [7:0] SIG_F      = 8'h46;
  localparam logic [7:0] SIG_EIGHT  = 8'h38;
  localparam logic [7:0] SIG_SEVEN  = 8'h37;
  localparam logic [7:0] SIG_NINE   = 8'h39;
  localparam logic [7:0] SIG_A      = 8'h61;

  localparam int unsigned TdataW = 104;
  localparam int unsigned TuserW = 3;

  typedef struct packed {
    event_e      event_res;
    logic [7:0]  data_byte;
    logic [15:0] width_px;
    logic [15:0] height_px;
    logic [15:0] left_px;
    logic [15:0] top_px;
    logic        interlaced;
    logic [7:0]  lzw_code_bits;
    logic [8:0]  palette_entries;
    logic        sorted_palette;
    logic        version_89a;
    logic [7:0]  image_index;
  } result_t;

  typedef struct packed {
    logic       fire;
    logic [7:0] file_byte;
  } in_word_t;

  typedef struct packed {
    logic    valid;
    result_t res;
  } res_word_t;

  function automatic logic [8:0] table_entries(input logic [2:0] size_code);
    table_entries = 9'd2 << size_code;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/gcp_parser.sv
// Phase machine that parses one file byte per cycle while bytes are accepted and forms its result word.
`default_nettype none

module gcp_parser (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire gcp_pkg::in_word_t in_i,
  output gcp_pkg::res_word_t     out_o
);

  logic [gcp_pkg::PhaseW-1:0] phase_q, phase_d;
  logic [9:0]  pos_q, pos_d;
  logic [7:0]  remain_q, remain_d;
  logic [7:0]  sflags_q, sflags_d;
  logic        v89_q, v89_d;
  logic [15:0] words_q [4];
  logic [15:0] words_d [4];
  logic [7:0]  iflags_q, iflags_d;
  logic [7:0]  images_q, images_d;
  logic        in_img_q, in_img_d;

  logic [7:0]  b;
  logic [2:0]  sig_pos;
  logic [7:0]  sig_expect;
  logic [8:0]  pal_n;
  logic [9:0]  pal_last;
  logic [8:0]  img_n;
  logic [2:0]  img_code;
  logic [3:0]  lzw_need;
  logic        img_sorted;
  logic        has_res;
  gcp_pkg::result_t res;

  assign b = in_i.file_byte;

  always_comb begin
    sig_pos = (pos_q < 10'd6) ? pos_q[2:0] : 3'd5;
    unique case (sig_pos)
      3'd0:    sig_expect = gcp_pkg::SIG_G;
      3'd1:    sig_expect = gcp_pkg::SIG_I;
      3'd2:    sig_expect = gcp_pkg::SIG_F;
      3'd3:    sig_expect = gcp_pkg::SIG_EIGHT;
      default: sig_expect = gcp_pkg::SIG_A;
    endcase
  end

  assign pal_n    = gcp_pkg::table_entries((phase_q == gcp_pkg::PH_GPAL) ?
                                           sflags_q[2:0] : iflags_q[2:0]);
  assign pal_last = ({1'b0, pal_n} << 1) + {1'b0, pal_n} - 10'd1;

  assign img_code   = iflags_q[7] ? iflags_q[2:0] : sflags_q[2:0];
  assign img_n      = gcp_pkg::table_entries(img_code);
  assign lzw_need   = (img_code == 3'd0) ? 4'd2 : ({1'b0, img_code} + 4'd1);
  assign img_sorted = v89_q & (iflags_q[7] ? iflags_q[5] : sflags_q[3]);

  always_comb begin
    phase_d  = phase_q;
    pos_d    = pos_q;
    remain_d = remain_q;
    sflags_d = sflags_q;
    v89_d    = v89_q;
    words_d  = words_q;
    iflags_d = iflags_q;
    images_d = images_q;
    in_img_d = in_img_q;
    has_res  = 1'b0;
    res      = '0;

    unique case (phase_q) inside
      gcp_pkg::PH_SIG: begin
        if (sig_pos == 3'd4) begin
          if (b == gcp_pkg::SIG_SEVEN) begin
            v89_d = 1'b0;
          end else if (b == gcp_pkg::SIG_NINE) begin
            v89_d = 1'b1;
          end else begin
            has_res = 1'b1;
          end
        end else if (b != sig_expect) begin
          has_res = 1'b1;
        end
        if (has_res) begin
          phase_d       = gcp_pkg::PH_HALT;
          res.event_res = gcp_pkg::EV_ERROR;
        end else if (sig_pos == 3'd5) begin
          phase_d = gcp_pkg::PH_LSD;
          pos_d   = '0;
        end else begin
          pos_d = {7'd0, sig_pos} + 10'd1;
        end
      end
      gcp_pkg::PH_LSD: begin
        if (pos_q < 10'd4) begin
          if (pos_q[0]) words_d[pos_q[2:1]][15:8] = b;
          else          words_d[pos_q[2:1]][7:0]  = b;
        end else if (pos_q == 10'd4) begin
          sflags_d = b;
        end
        if (pos_q < 10'd6) begin
          pos_d = pos_q + 10'd1;
        end else begin
          has_res       = 1'b1;
          res.event_res = gcp_pkg::EV_SCREEN;
          res.width_px  = words_q[0];
          res.height_px = words_q[1];
          res.version_89a = v89_q;
          if (sflags_q[7]) begin
            res.palette_entries = gcp_pkg::table_entries(sflags_q[2:0]);
            res.sorted_palette  = v89_q & sflags_q[3];
            phase_d = gcp_pkg::PH_GPAL;
          end else begin
            phase_d = gcp_pkg::PH_INTRO;
          end
          pos_d = '0;
        end
      end
      gcp_pkg::PH_GPAL, gcp_pkg::PH_LPAL: begin
        has_res       = 1'b1;
        res.event_res = gcp_pkg::EV_PAL;
        res.data_byte = b;
        if (pos_q >= pal_last) begin
          phase_d = (phase_q == gcp_pkg::PH_GPAL) ? gcp_pkg::PH_INTRO : gcp_pkg::PH_CODESIZE;
          pos_d   = '0;
        end else begin
          pos_d = pos_q + 10'd1;
        end
      end
      gcp_pkg::PH_INTRO: begin
        pos_d = '0;
        if (b == gcp_pkg::INTRO_IMAGE) begin
          phase_d = gcp_pkg::PH_IDESC;
        end else if (b == gcp_pkg::INTRO_EXT) begin
          phase_d = gcp_pkg::PH_EXTLABEL;
        end else if (b == gcp_pkg::INTRO_TRAILER) begin
          phase_d       = gcp_pkg::PH_DONE;
          has_res       = 1'b1;
          res.event_res = gcp_pkg::EV_TRAILER;
        end else begin
          phase_d       = gcp_pkg::PH_HALT;
          has_res       = 1'b1;
          res.event_res = gcp_pkg::EV_ERROR;
        end
      end
      gcp_pkg::PH_IDESC: begin
        if (pos_q < 10'd8) begin
          if (pos_q[0]) words_d[pos_q[2:1]][15:8] = b;
          else          words_d[pos_q[2:1]][7:0]  = b;
          pos_d = pos_q + 10'd1;
        end else begin
          iflags_d = b;
          pos_d    = '0;
          if (b[7]) begin
            phase_d = gcp_pkg::PH_LPAL;
          end else if (!sflags_q[7]) begin
            phase_d       = gcp_pkg::PH_HALT;
            has_res       = 1'b1;
            res.event_res = gcp_pkg::EV_ERROR;
          end else begin
            phase_d = gcp_pkg::PH_CODESIZE;
          end
        end
      end
      gcp_pkg::PH_CODESIZE: begin
        has_res = 1'b1;
        if (b != {4'd0, lzw_need}) begin
          phase_d       = gcp_pkg::PH_HALT;
          res.event_res = gcp_pkg::EV_ERROR;
        end else begin
          res.event_res       = gcp_pkg::EV_IMAGE;
          res.width_px        = words_q[2];
          res.height_px       = words_q[3];
          res.left_px         = words_q[0];
          res.top_px          = words_q[1];
          res.interlaced      = iflags_q[6];
          res.lzw_code_bits   = b;
          res.palette_entries = img_n;
          res.sorted_palette  = img_sorted;
          res.version_89a     = v89_q;
          res.image_index     = images_q;
          if (images_q != 8'hFF) images_d = images_q + 8'd1;
          in_img_d = 1'b1;
          phase_d  = gcp_pkg::PH_BLKLEN;
          pos_d    = '0;
        end
      end
      gcp_pkg::PH_EXTLABEL: begin
        in_img_d = 1'b0;
        phase_d  = gcp_pkg::PH_BLKLEN;
      end
      gcp_pkg::PH_BLKLEN: begin
        if (b == 8'd0) begin
          phase_d = gcp_pkg::PH_INTRO;
          if (in_img_q) begin
            in_img_d      = 1'b0;
            has_res       = 1'b1;
            res.event_res = gcp_pkg::EV_END;
          end
        end else begin
          remain_d = b;
          phase_d  = gcp_pkg::PH_BLKDATA;
        end
      end
      gcp_pkg::PH_BLKDATA: begin
        if (remain_q <= 8'd1) begin
          remain_d = '0;
          phase_d  = gcp_pkg::PH_BLKLEN;
        end else begin
          remain_d = remain_q - 8'd1;
        end
        if (in_img_q) begin
          has_res       = 1'b1;
          res.event_res = gcp_pkg::EV_DATA;
          res.data_byte = b;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= gcp_pkg::PH_SIG;
      pos_q    <= '0;
      remain_q <= '0;
      sflags_q <= '0;
      v89_q    <= 1'b0;
      words_q  <= '{default: '0};
      iflags_q <= '0;
      images_q <= '0;
      in_img_q <= 1'b0;
    end else if (in_i.fire) begin
      phase_q  <= phase_d;
      pos_q    <= pos_d;
      remain_q <= remain_d;
      sflags_q <= sflags_d;
      v89_q    <= v89_d;
      words_q  <= words_d;
      iflags_q <= iflags_d;
      images_q <= images_d;
      in_img_q <= in_img_d;
    end
  end

  assign out_o.valid = in_i.fire & has_res;
  assign out_o.res   = res;

endmodule

`default_nettype wire

// File: rtl/core/gcp_out_buf.sv
// Result register with a skid stage so input acceptance survives an output stall.
`default_nettype none

module gcp_out_buf (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire gcp_pkg::res_word_t in_i,
  output logic                    ready_o,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output gcp_pkg::result_t        res_o
);

  logic             out_valid_q, out_valid_d;
  logic             skid_valid_q, skid_valid_d;
  gcp_pkg::result_t out_q, skid_q;
  logic             out_free;

  assign out_free = !out_valid_q || ready_i;
  assign ready_o  = !skid_valid_q;

  always_comb begin
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (skid_valid_q) begin
      if (ready_i) begin
        out_valid_d  = 1'b1;
        skid_valid_d = 1'b0;
      end
    end else if (out_free) begin
      out_valid_d = in_i.valid;
    end else if (in_i.valid) begin
      skid_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (ready_i) out_q <= skid_q;
    end else if (out_free) begin
      if (in_i.valid) out_q <= in_i.res;
    end else if (in_i.valid) begin
      skid_q <= in_i.res;
    end
  end

  assign valid_o = out_valid_q;
  assign res_o   = out_q;

endmodule

`default_nettype wire

// File: rtl/core/gif_container_stream_parser.sv
// Top level of the GIF container stream parser: byte stream in, parse event words out.
//
//  Channel   Dir  Payload                                 Accepted when
//  s_axis    in   tdata[7:0] = file_byte                  s_axis_tvalid_i && s_axis_tready_o
//  m_axis    out  tdata = result fields, tuser = event    m_axis_tvalid_o && m_axis_tready_i
//
// Each byte yields at most one event word, which is registered in the output stage before it appears.
// The phase machine in the parser decodes every byte combinationally and registers its state when the byte is taken.
// A two-entry output stage keeps taking bytes while a result word is stalled.
// The input stalls only while both entries of the output stage hold words.
// Reset returns the parser to expecting the signature and empties the output stage.
`default_nettype none

module gif_container_stream_parser (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // [7:0] file_byte
  input  wire logic [7:0]                    s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  wire logic                          m_axis_tready_i,
  // [7:0] data_byte, [23:8] width_px, [39:24] height_px, [55:40] left_px,
  // [71:56] top_px, [72] interlaced, [80:73] lzw_code_bits, [89:81] palette_entries,
  // [90] sorted_palette, [91] version_89a, [99:92] image_index, [103:100] zero
  output logic [gcp_pkg::TdataW-1:0]         m_axis_tdata_o,
  // [2:0] event_res
  output logic [gcp_pkg::TuserW-1:0]         m_axis_tuser_o
);

  gcp_pkg::in_word_t  in_word;
  gcp_pkg::res_word_t res_word;
  gcp_pkg::result_t   res;

  assign in_word.fire      = s_axis_tvalid_i & s_axis_tready_o;
  assign in_word.file_byte = s_axis_tdata_i;

  gcp_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_word),
    .out_o  (res_word)
  );

  gcp_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (res_word),
    .ready_o (s_axis_tready_o),
    .valid_o (m_axis_tvalid_o),
    .ready_i (m_axis_tready_i),
    .res_o   (res)
  );

  assign m_axis_tuser_o = res.event_res;
  assign m_axis_tdata_o = {4'd0, res.image_index, res.version_89a, res.sorted_palette,
                           res.palette_entries, res.lzw_code_bits, res.interlaced,
                           res.top_px, res.left_px, res.height_px, res.width_px,
                           res.data_byte};

endmodule

`default_nettype wire

// File: rtl/core/gcp_checker.sv
// Port-level checker of the GIF container stream parser and its bind.
`default_nettype none

module gcp_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          m_axis_tvalid_o,
  input wire logic                          m_axis_tready_i,
  input wire logic [gcp_pkg::TdataW-1:0]    m_axis_tdata_o,
  input wire logic [gcp_pkg::TuserW-1:0]    m_axis_tuser_o
);

  logic out_fire;
  assign out_fire = m_axis_tvalid_o & m_axis_tready_i;

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o)
    else $error("Output word dropped while stalled.");

  a_payload_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("Output word changed while stalled.");

  a_event_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tuser_o != 3'd7)
    else $error("Output word carries an undefined event code.");

  a_terminal_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_fire && (m_axis_tuser_o == gcp_pkg::EV_ERROR || m_axis_tuser_o == gcp_pkg::EV_TRAILER)
    |=> !m_axis_tvalid_o)
    else $error("Output word followed an error or trailer word.");

  a_error_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == gcp_pkg::EV_ERROR |-> m_axis_tdata_o == '0)
    else $error("Error word carries nonzero fields.");

endmodule

bind gif_container_stream_parser gcp_checker u_gcp_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

`default_nettype wire
